/* src/ffha_pkg.sv */
// shared types and constants for the first-fit heap allocator
// no dependencies
package ffha_pkg;

    localparam int unsigned SIZE_W   = 25;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned SLACK    = 8;
    localparam logic [SIZE_W-1:0] HEAP_BYTES_RST = 25'd16777216;
    localparam logic [ADDR_W-1:0] HEAP_BASE_RST  = 32'h0010_0000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_NO_MEMORY = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_UNKNOWN   = 3'd4
    } t_status;

    typedef enum logic {
        ACT_ALLOC   = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_BYTES = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_EV,
        S_A_SPL,
        S_A_APP,
        S_A_TAIL,
        S_R_EV,
        S_M_RD,
        S_M_LD,
        S_M_EV,
        S_M_EV2,
        S_RESP
    } t_state;

endpackage

/* src/ffha_req_if.sv */
// request channel of the heap allocator
// depends on ffha_pkg
interface ffha_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [ffha_pkg::SIZE_W-1:0]  request_bytes;
    logic [ffha_pkg::ADDR_W-1:0]  release_address;

    modport source (output valid, action, request_bytes, release_address, input ready);
    modport sink (input valid, action, request_bytes, release_address, output ready);
endinterface

/* src/ffha_rsp_if.sv */
// response channel of the heap allocator
// depends on ffha_pkg
interface ffha_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffha_pkg::ADDR_W-1:0]   payload_address;
    logic [ffha_pkg::STATUS_W-1:0] status;

    modport source (output valid, payload_address, status, input ready);
    modport sink (input valid, payload_address, status, output ready);
endinterface

/* src/ffha_seg_table.sv */
// segment table memory: one write port, one registered read port
// depends on ffha_pkg
module ffha_seg_table #(
    parameter int unsigned MAX_SEGMENTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [$clog2(MAX_SEGMENTS)-1:0]     i_waddr,
    input  logic [ffha_pkg::SIZE_W-1:0]         i_w_off,
    input  logic [ffha_pkg::SIZE_W-1:0]         i_w_size,
    input  logic                                i_w_free,
    input  logic [$clog2(MAX_SEGMENTS)-1:0]     i_w_link,
    input  logic                                i_w_has,
    input  logic [$clog2(MAX_SEGMENTS)-1:0]     i_raddr,
    output logic [ffha_pkg::SIZE_W-1:0]         o_r_off,
    output logic [ffha_pkg::SIZE_W-1:0]         o_r_size,
    output logic                                o_r_free,
    output logic [$clog2(MAX_SEGMENTS)-1:0]     o_r_link,
    output logic                                o_r_has
);
    localparam int unsigned IW = $clog2(MAX_SEGMENTS);
    localparam int unsigned RW = 2 * ffha_pkg::SIZE_W + IW + 2;

    logic [RW-1:0] mem [MAX_SEGMENTS];
    logic [RW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_w_off, i_w_size, i_w_free, i_w_link, i_w_has};
        end
        r_rd <= mem[i_raddr];
    end

    assign {o_r_off, o_r_size, o_r_free, o_r_link, o_r_has} = r_rd;
endmodule

/* src/ffha_pool.sv */
// entry pool: in-use bits, lowest free entry and entry count
// depends on nothing beyond its parameter
module ffha_pool #(
    parameter int unsigned MAX_SEGMENTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_grab,
    input  logic                                i_rel,
    input  logic [$clog2(MAX_SEGMENTS)-1:0]     i_rel_idx,
    output logic [$clog2(MAX_SEGMENTS)-1:0]     o_free_idx,
    output logic [$clog2(MAX_SEGMENTS+1)-1:0]   o_count,
    output logic                                o_full
);
    localparam int unsigned IW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

    logic [MAX_SEGMENTS-1:0] r_used;
    logic [CW-1:0]           r_count;

    always_comb begin
        o_free_idx = '0;
        for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
            if (!r_used[i]) o_free_idx = IW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
        end else if (i_grab) begin
            r_used[o_free_idx] <= 1'b1;
            r_count            <= r_count + CW'(1);
        end else if (i_rel) begin
            r_used[i_rel_idx] <= 1'b0;
            r_count           <= r_count - CW'(1);
        end
    end

    assign o_count = r_count;
    assign o_full  = (r_count >= CW'(MAX_SEGMENTS));
endmodule

/* src/first_fit_heap_allocator_unit.sv */
// first-fit heap allocator with split and coalesce, top level
// depends on ffha_pkg, ffha_req_if, ffha_rsp_if, ffha_seg_table, ffha_pool
//
// One request at a time. The allocate and release lookups visit one segment per clock through
// the single read port of the segment table. An allocate walks the list for the first free
// segment that fits and splits off the remainder as a new free segment when it is large enough
// and the table has room; failing a fit, it appends a new segment at the heap top and links it
// behind the last segment, if any. A release looks up the segment and then makes a coalesce
// pass over the list. The response sits in an output register, and a new request is taken once
// the previous response has moved into it.
module first_fit_heap_allocator_unit #(
    parameter int unsigned MAX_SEGMENTS = 64,
    parameter int unsigned HEADER_BYTES = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ffha_req_if.sink            i_req,
    ffha_rsp_if.source          o_rsp,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);
    localparam int unsigned IW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned NW = $clog2(2 * MAX_SEGMENTS + 1);
    localparam int unsigned SW = ffha_pkg::SIZE_W;
    localparam int unsigned AW = ffha_pkg::ADDR_W;
    localparam int unsigned WW = SW + 2;
    localparam logic [WW-1:0] HDR_W   = WW'(HEADER_BYTES);
    localparam logic [WW-1:0] SLACK_W = WW'(ffha_pkg::SLACK);
    localparam logic [AW-1:0] HDR_A   = AW'(HEADER_BYTES);

    ffha_pkg::t_state r_state, n_state;

    logic [AW-1:0]  r_base;
    logic [SW-1:0]  r_hbytes;
    logic [IW-1:0]  r_head, n_head;
    logic [SW-1:0]  r_top, n_top;
    logic [IW-1:0]  r_cur, n_cur;
    logic [NW-1:0]  r_n, n_n;
    logic [SW:0]    r_need, n_need;
    logic [AW-1:0]  r_addr, n_addr;
    logic           r_have_tail, n_have_tail;
    logic [IW-1:0]  r_t_idx, n_t_idx;
    logic [SW-1:0]  r_t_off, n_t_off;
    logic [SW-1:0]  r_t_size, n_t_size;
    logic           r_t_free, n_t_free;
    logic [IW-1:0]  r_e, n_e;
    logic [SW-1:0]  r_x_off, n_x_off;
    logic [SW-1:0]  r_x_size, n_x_size;
    logic [IW-1:0]  r_x_link, n_x_link;
    logic           r_x_has, n_x_has;
    logic [SW-1:0]  r_c_off, n_c_off;
    logic [SW-1:0]  r_c_size, n_c_size;
    logic           r_c_free, n_c_free;
    logic [IW-1:0]  r_c_link, n_c_link;
    logic           r_c_has, n_c_has;
    logic [AW-1:0]  r_res_addr, n_res_addr;
    logic [ffha_pkg::STATUS_W-1:0] r_res_st, n_res_st;
    logic           r_out_valid;
    logic [AW-1:0]  r_out_addr;
    logic [ffha_pkg::STATUS_W-1:0] r_out_st;

    logic           we;
    logic [IW-1:0]  waddr, raddr;
    logic [SW-1:0]  w_off, w_size;
    logic           w_free, w_has;
    logic [IW-1:0]  w_link;
    logic [SW-1:0]  rd_off, rd_size;
    logic           rd_free, rd_has;
    logic [IW-1:0]  rd_link;

    logic           grab, rel;
    logic [IW-1:0]  rel_idx, free_idx;
    logic [CW-1:0]  count;
    logic           full;

    logic [WW-1:0]  need_w, size_w, split_lim, app_sum, merge_sum;
    logic [AW-1:0]  rd_payload;
    logic           out_load;

    ffha_seg_table #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_table (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_w_off  (w_off),
        .i_w_size (w_size),
        .i_w_free (w_free),
        .i_w_link (w_link),
        .i_w_has  (w_has),
        .i_raddr  (raddr),
        .o_r_off  (rd_off),
        .o_r_size (rd_size),
        .o_r_free (rd_free),
        .o_r_link (rd_link),
        .o_r_has  (rd_has)
    );

    ffha_pool #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_pool (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_grab     (grab),
        .i_rel      (rel),
        .i_rel_idx  (rel_idx),
        .o_free_idx (free_idx),
        .o_count    (count),
        .o_full     (full)
    );

    assign need_w     = WW'(r_need);
    assign size_w     = WW'(rd_size);
    assign split_lim  = need_w + HDR_W + SLACK_W;
    assign app_sum    = WW'(r_top) + need_w + HDR_W;
    assign merge_sum  = WW'(r_c_size) + HDR_W + WW'(rd_size);
    assign rd_payload = r_base + AW'(rd_off) + HDR_A;

    assign i_req.ready     = (r_state == ffha_pkg::S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.payload_address = r_out_addr;
    assign o_rsp.status    = r_out_st;
    assign out_load = (r_state == ffha_pkg::S_RESP) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        n_head = r_head; n_top = r_top; n_cur = r_cur; n_n = r_n; n_need = r_need;
        n_addr = r_addr; n_have_tail = r_have_tail;
        n_t_idx = r_t_idx; n_t_off = r_t_off; n_t_size = r_t_size; n_t_free = r_t_free;
        n_e = r_e; n_x_off = r_x_off; n_x_size = r_x_size; n_x_link = r_x_link;
        n_x_has = r_x_has;
        n_c_off = r_c_off; n_c_size = r_c_size; n_c_free = r_c_free; n_c_link = r_c_link;
        n_c_has = r_c_has;
        n_res_addr = r_res_addr; n_res_st = r_res_st;
        we = 1'b0; waddr = r_cur; w_off = '0; w_size = '0; w_free = 1'b0; w_link = '0;
        w_has = 1'b0;
        raddr = r_cur;
        grab = 1'b0; rel = 1'b0; rel_idx = '0;

        unique case (r_state)
            ffha_pkg::S_IDLE: begin
                raddr = r_head;
                if (i_req.valid) begin
                    n_cur = r_head;
                    n_n = '0;
                    n_have_tail = 1'b0;
                    n_res_addr = '0;
                    n_res_st = ffha_pkg::ST_OK;
                    n_need = (SW+1)'(({1'b0, i_req.request_bytes} + (SW+1)'(3)) &
                             ~(SW+1)'(3));
                    n_addr = i_req.release_address;
                    if (i_req.action == ffha_pkg::ACT_ALLOC) begin
                        if (i_req.request_bytes == '0) begin
                            n_res_st = ffha_pkg::ST_ZERO_SIZE;
                            n_state = ffha_pkg::S_RESP;
                        end else if (count == '0) begin
                            n_state = ffha_pkg::S_A_APP;
                        end else begin
                            n_state = ffha_pkg::S_A_EV;
                        end
                    end else begin
                        if (i_req.release_address == '0) begin
                            n_state = ffha_pkg::S_RESP;
                        end else if (count == '0) begin
                            n_res_st = ffha_pkg::ST_UNKNOWN;
                            n_state = ffha_pkg::S_RESP;
                        end else begin
                            n_state = ffha_pkg::S_R_EV;
                        end
                    end
                end
            end
            ffha_pkg::S_A_EV: begin
                if (rd_free && size_w >= need_w) begin
                    we = 1'b1;
                    waddr = r_cur;
                    w_off = rd_off;
                    n_res_addr = rd_payload;
                    n_state = ffha_pkg::S_RESP;
                    if (size_w > split_lim && !full) begin
                        grab = 1'b1;
                        n_e = free_idx;
                        n_x_off = SW'(WW'(rd_off) + HDR_W + need_w);
                        n_x_size = SW'(size_w - need_w - HDR_W);
                        n_x_link = rd_link;
                        n_x_has = rd_has;
                        w_size = SW'(r_need);
                        w_link = free_idx;
                        w_has = 1'b1;
                        n_state = ffha_pkg::S_A_SPL;
                    end else begin
                        w_size = rd_size;
                        w_link = rd_link;
                        w_has = rd_has;
                    end
                end else begin
                    n_t_idx = r_cur;
                    n_t_off = rd_off;
                    n_t_size = rd_size;
                    n_t_free = rd_free;
                    n_have_tail = 1'b1;
                    n_n = r_n + NW'(1);
                    if (!rd_has || (r_n + NW'(1)) == NW'(MAX_SEGMENTS)) begin
                        n_state = ffha_pkg::S_A_APP;
                    end else begin
                        n_cur = rd_link;
                        raddr = rd_link;
                    end
                end
            end
            ffha_pkg::S_A_SPL: begin
                we = 1'b1;
                waddr = r_e;
                w_off = r_x_off;
                w_size = r_x_size;
                w_free = 1'b1;
                w_link = r_x_link;
                w_has = r_x_has;
                n_state = ffha_pkg::S_RESP;
            end
            ffha_pkg::S_A_APP: begin
                n_state = ffha_pkg::S_RESP;
                if (app_sum > WW'(r_hbytes)) begin
                    n_res_st = ffha_pkg::ST_NO_MEMORY;
                end else if (full) begin
                    n_res_st = ffha_pkg::ST_TABLE_FULL;
                end else begin
                    grab = 1'b1;
                    n_e = free_idx;
                    we = 1'b1;
                    waddr = free_idx;
                    w_off = r_top;
                    w_size = SW'(r_need);
                    n_top = SW'(app_sum);
                    n_res_addr = r_base + AW'(r_top) + HDR_A;
                    if (r_have_tail) begin
                        n_state = ffha_pkg::S_A_TAIL;
                    end else begin
                        n_head = free_idx;
                    end
                end
            end
            ffha_pkg::S_A_TAIL: begin
                we = 1'b1;
                waddr = r_t_idx;
                w_off = r_t_off;
                w_size = r_t_size;
                w_free = r_t_free;
                w_link = r_e;
                w_has = 1'b1;
                n_state = ffha_pkg::S_RESP;
            end
            ffha_pkg::S_R_EV: begin
                if (rd_payload == r_addr) begin
                    we = 1'b1;
                    waddr = r_cur;
                    w_off = rd_off;
                    w_size = rd_size;
                    w_free = 1'b1;
                    w_link = rd_link;
                    w_has = rd_has;
                    n_state = ffha_pkg::S_M_RD;
                end else begin
                    n_n = r_n + NW'(1);
                    if (!rd_has || (r_n + NW'(1)) == NW'(MAX_SEGMENTS)) begin
                        n_res_st = ffha_pkg::ST_UNKNOWN;
                        n_state = ffha_pkg::S_RESP;
                    end else begin
                        n_cur = rd_link;
                        raddr = rd_link;
                    end
                end
            end
            ffha_pkg::S_M_RD: begin
                raddr = r_head;
                n_cur = r_head;
                n_n = '0;
                n_state = ffha_pkg::S_M_LD;
            end
            ffha_pkg::S_M_LD: begin
                n_c_off = rd_off;
                n_c_size = rd_size;
                n_c_free = rd_free;
                n_c_link = rd_link;
                n_c_has = rd_has;
                n_state = ffha_pkg::S_M_EV;
            end
            ffha_pkg::S_M_EV: begin
                raddr = r_c_link;
                if (!r_c_has || r_n == NW'(2 * MAX_SEGMENTS)) begin
                    n_state = ffha_pkg::S_RESP;
                end else begin
                    n_state = ffha_pkg::S_M_EV2;
                end
            end
            ffha_pkg::S_M_EV2: begin
                n_n = r_n + NW'(1);
                n_state = ffha_pkg::S_M_EV;
                if (r_c_free && rd_free) begin
                    n_c_size = SW'(merge_sum);
                    n_c_link = rd_link;
                    n_c_has = rd_has;
                    we = 1'b1;
                    waddr = r_cur;
                    w_off = r_c_off;
                    w_size = SW'(merge_sum);
                    w_free = r_c_free;
                    w_link = rd_link;
                    w_has = rd_has;
                    rel = 1'b1;
                    rel_idx = r_c_link;
                end else begin
                    n_cur = r_c_link;
                    n_c_off = rd_off;
                    n_c_size = rd_size;
                    n_c_free = rd_free;
                    n_c_link = rd_link;
                    n_c_has = rd_has;
                end
            end
            ffha_pkg::S_RESP: begin
                if (out_load) n_state = ffha_pkg::S_IDLE;
            end
            default: n_state = ffha_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= ffha_pkg::HEAP_BASE_RST;
            r_hbytes    <= ffha_pkg::HEAP_BYTES_RST;
            r_head      <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == ffha_pkg::CFG_HEAP_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_hbytes <= i_cfg_data[SW-1:0];
                end
            end
            r_head <= n_head;
            r_top  <= n_top;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur; r_n <= n_n; r_need <= n_need; r_addr <= n_addr;
        r_have_tail <= n_have_tail;
        r_t_idx <= n_t_idx; r_t_off <= n_t_off; r_t_size <= n_t_size; r_t_free <= n_t_free;
        r_e <= n_e; r_x_off <= n_x_off; r_x_size <= n_x_size; r_x_link <= n_x_link;
        r_x_has <= n_x_has;
        r_c_off <= n_c_off; r_c_size <= n_c_size; r_c_free <= n_c_free;
        r_c_link <= n_c_link; r_c_has <= n_c_has;
        r_res_addr <= n_res_addr; r_res_st <= n_res_st;
        if (out_load) begin
            r_out_addr <= r_res_addr;
            r_out_st   <= r_res_st;
        end
    end
endmodule
